[rtl/core/i4bdp_pkg.sv]
package i4bdp_pkg;

  // Sizing of the datapath
  localparam int unsigned NumCandidates = 4;
  localparam int unsigned LengthBits    = 32;
  localparam int unsigned AccBits       = LengthBits + 9;
  localparam int unsigned ByteBits      = 8;
  localparam int unsigned NibBits       = 4;
  localparam int unsigned ProdBits      = 9;

  // Nibble decode constants: value = (n xor 8) - 8
  localparam logic [NibBits-1:0] NibMask = 4'hf;
  localparam logic [NibBits-1:0] NibBias = 4'h8;

  typedef logic [ByteBits-1:0]        byte_t;
  typedef logic signed [AccBits-1:0]  acc_t;
  typedef logic signed [ProdBits-1:0] prod_t;

  // Decode one packed nibble as a signed int4
  function automatic logic signed [NibBits:0] nib_value(input logic [NibBits-1:0] n);
    logic [NibBits:0] biased;
    biased = {1'b0, (n & NibMask) ^ NibBias};
    return $signed(biased) - $signed({1'b0, NibBias});
  endfunction

  // Low times low plus high times high; range -112 .. 128
  function automatic prod_t pair_product(input byte_t q, input byte_t c);
    logic signed [2*NibBits+1:0] lo;
    logic signed [2*NibBits+1:0] hi;
    lo = (2*NibBits+2)'(nib_value(q[NibBits-1:0])) *
         (2*NibBits+2)'(nib_value(c[NibBits-1:0]));
    hi = (2*NibBits+2)'(nib_value(q[ByteBits-1:NibBits])) *
         (2*NibBits+2)'(nib_value(c[ByteBits-1:NibBits]));
    return ProdBits'(lo + hi);
  endfunction

endpackage

[rtl/core/int4_batch_dot_product.sv]
// After the input transfer of the last byte, the result passes the input register,
// then is accumulated into the result register that drives the output port.
// Throughput: one byte position per cycle; the only stall is a last byte
// waiting while the previous result is still held on the output port.
// Reset (rst_ni low, asynchronous): running sums clear to zero, both stages empty.
module int4_batch_dot_product (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  i4bdp_pkg::byte_t       query_byte_i,
  input  i4bdp_pkg::byte_t       cand_a_byte_i,
  input  i4bdp_pkg::byte_t       cand_b_byte_i,
  input  i4bdp_pkg::byte_t       cand_c_byte_i,
  input  i4bdp_pkg::byte_t       cand_d_byte_i,
  input  logic                   last_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output i4bdp_pkg::acc_t        dot_a_o,
  output i4bdp_pkg::acc_t        dot_b_o,
  output i4bdp_pkg::acc_t        dot_c_o,
  output i4bdp_pkg::acc_t        dot_d_o
);
  import i4bdp_pkg::*;

  // Input stage
  logic  s1_valid_q;
  logic  s1_last_q;
  byte_t query_q;
  byte_t cand_q [NumCandidates];
  byte_t cand_in [NumCandidates];

  // Accumulators and result register
  acc_t acc_q  [NumCandidates];
  acc_t sum_d  [NumCandidates];
  acc_t dot_q  [NumCandidates];
  logic out_valid_q;

  logic s1_adv;
  logic in_xfer;
  logic acc_zero;

  assign cand_in[0] = cand_a_byte_i;
  assign cand_in[1] = cand_b_byte_i;
  assign cand_in[2] = cand_c_byte_i;
  assign cand_in[3] = cand_d_byte_i;

  // Advance the input stage unless a last byte finds the result register occupied
  assign s1_adv     = s1_valid_q && !(s1_last_q && out_valid_q && !out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Capture the input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
      s1_last_q  <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      query_q <= query_byte_i;
      for (int j = 0; j < NumCandidates; j++) begin
        cand_q[j] <= cand_in[j];
      end
    end
  end

  // Add both nibble products into each running sum
  always_comb begin
    for (int j = 0; j < NumCandidates; j++) begin
      sum_d[j] = acc_q[j] + AccBits'(pair_product(query_q, cand_q[j]));
    end
  end

  // Accumulate, and clear the sums after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NumCandidates; j++) begin
        acc_q[j] <= '0;
      end
    end else if (s1_adv) begin
      for (int j = 0; j < NumCandidates; j++) begin
        acc_q[j] <= s1_last_q ? '0 : sum_d[j];
      end
    end
  end

  // Result register: load on last byte, drop on output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      for (int j = 0; j < NumCandidates; j++) begin
        dot_q[j] <= sum_d[j];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign dot_a_o     = dot_q[0];
  assign dot_b_o     = dot_q[1];
  assign dot_c_o     = dot_q[2];
  assign dot_d_o     = dot_q[3];

  always_comb begin
    acc_zero = 1'b1;
    for (int j = 0; j < NumCandidates; j++) begin
      acc_zero = acc_zero && (acc_q[j] == '0);
    end
  end

  // A last byte that leaves the input stage clears every running sum
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> acc_zero)
    else $error("running sums not cleared after last byte");

  // A result appears only after a last byte left the input stage
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q && s1_last_q))
    else $error("result without last byte");

  // A held result blocks a waiting last byte and new input
  a_last_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("last byte overwrote held result");

  // A byte without the last mark never touches the result register
  a_no_result_midway: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && !(s1_valid_q && s1_last_q)) |=>
      (out_valid_o && $stable(dot_a_o)))
    else $error("result register changed without last byte");

endmodule
